/* rtl/symmetric_gauss_line_smoother_top_assert.svh */
// assertion macros for the line smoother, clocked on clk, quiet in reset
`ifndef SYMMETRIC_GAUSS_LINE_SMOOTHER_TOP_ASSERT_SVH
`define SYMMETRIC_GAUSS_LINE_SMOOTHER_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define SGLS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SGLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sgls_pkg.sv */
`default_nettype none

package sgls_pkg;

	localparam int MAX_RADIUS_DEF = 6;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int MAX_LINE_DEF   = 4096;

	localparam int PIX_W   = 16;
	localparam int POS_W   = 12;
	localparam int OUT_W   = 31;
	localparam int RAD_W   = 3;
	localparam int RAD_MAX = (1 << RAD_W) - 1;
	localparam int WGT_W   = 10;
	localparam int NUM_WTS = 7;
	localparam int CFG_W   = 32;
	localparam int ADDR_W  = 5;

	typedef logic [WGT_W-1:0] weight_t;
	typedef weight_t [NUM_WTS-1:0] weights_t;

	typedef enum logic [2:0] {
		REG_RADIUS   = 3'd0,
		REG_W_CENTER = 3'd1,
		REG_W_OFF1   = 3'd2,
		REG_W_OFF2   = 3'd3,
		REG_W_OFF3   = 3'd4,
		REG_W_OFF4   = 3'd5,
		REG_W_OFF5   = 3'd6,
		REG_W_OFF6   = 3'd7
	} cfg_reg_t;

	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(2);
	localparam weights_t WTS_RST = {WGT_W'(0), WGT_W'(0), WGT_W'(0), WGT_W'(0),
		WGT_W'(6), WGT_W'(25), WGT_W'(41)};

	localparam logic [OUT_W-1:0] SUM_MAX = '1;

	typedef struct packed {
		logic             shift;
		logic             load;
		logic [RAD_W-1:0] radius;
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/sgls_if.sv */
`default_nettype none

interface sgls_pixel_if;
	import sgls_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	logic             line_end;

	modport source (output valid, output pixel, output line_end, input ready);
	modport sink (input valid, input pixel, input line_end, output ready);
endinterface

interface sgls_result_if;
	import sgls_pkg::*;

	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] smoothed;
	logic [POS_W-1:0] position;
	logic             saturated;

	modport source (output valid, output smoothed, output position, output saturated,
		input ready);
	modport sink (input valid, input smoothed, input position, input saturated,
		output ready);
endinterface

`default_nettype wire

/* rtl/symmetric_gauss_line_smoother_top.sv */
// a result passes the s0, s1, s2 and s3 registers after its item is accepted
// throughput: one pixel per cycle unless results.ready stalls; window shifts per item
// stages: window cells, per-tap products, group sums, final sum and clip
// reset: window cleared to zero, line position zero, radius 2, weights 41 25 6 0 0 0 0
`default_nettype none

module symmetric_gauss_line_smoother_top #(
	parameter int MAX_RADIUS = sgls_pkg::MAX_RADIUS_DEF,
	parameter int PIXEL_BITS = sgls_pkg::PIXEL_BITS_DEF,
	parameter int MAX_LINE   = sgls_pkg::MAX_LINE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sgls_pixel_if.sink                    pixels,
	sgls_result_if.source                 results,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sgls_pkg::ADDR_W-1:0]   paddr,
	input  logic [sgls_pkg::CFG_W-1:0]    pwdata,
	output logic [sgls_pkg::CFG_W-1:0]    prdata,
	output logic                          pready
);
	import sgls_pkg::*;

	localparam int EFF_MAX = (MAX_RADIUS < RAD_MAX) ? MAX_RADIUS : RAD_MAX;
	localparam int NTAP    = 2 * EFF_MAX + 1;
	localparam int LINE_W  = $clog2(MAX_LINE);
	localparam int PROD_W  = PIXEL_BITS + WGT_W;
	localparam int GRP     = 4;
	localparam int NGRP    = (NTAP + GRP - 1) / GRP;
	localparam int GRP_W   = PROD_W + 2;
	localparam int SUM_W   = PROD_W + 4;
	localparam int EXT_W   = (SUM_W > OUT_W) ? SUM_W : OUT_W;

	// configuration
	logic [RAD_W-1:0] radius_q;
	weights_t         wts_q;
	logic             cfg_wr;
	cfg_reg_t         cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			wts_q    <= WTS_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_RADIUS:   radius_q <= pwdata[RAD_W-1:0];
				REG_W_CENTER: wts_q[0] <= pwdata[WGT_W-1:0];
				REG_W_OFF1:   wts_q[1] <= pwdata[WGT_W-1:0];
				REG_W_OFF2:   wts_q[2] <= pwdata[WGT_W-1:0];
				REG_W_OFF3:   wts_q[3] <= pwdata[WGT_W-1:0];
				REG_W_OFF4:   wts_q[4] <= pwdata[WGT_W-1:0];
				REG_W_OFF5:   wts_q[5] <= pwdata[WGT_W-1:0];
				REG_W_OFF6:   wts_q[6] <= pwdata[WGT_W-1:0];
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_RADIUS:   prdata = CFG_W'(radius_q);
			REG_W_CENTER: prdata = CFG_W'(wts_q[0]);
			REG_W_OFF1:   prdata = CFG_W'(wts_q[1]);
			REG_W_OFF2:   prdata = CFG_W'(wts_q[2]);
			REG_W_OFF3:   prdata = CFG_W'(wts_q[3]);
			REG_W_OFF4:   prdata = CFG_W'(wts_q[4]);
			REG_W_OFF5:   prdata = CFG_W'(wts_q[5]);
			REG_W_OFF6:   prdata = CFG_W'(wts_q[6]);
		endcase
	end

	// effective radius
	logic [RAD_W-1:0] r_eff;

	always_comb begin
		if (int'(radius_q) > MAX_RADIUS) begin
			r_eff = RAD_W'(MAX_RADIUS);
		end else begin
			r_eff = radius_q;
		end
	end

	// pipeline handshake, a stage takes a new item when empty or draining
	logic vld_s0, vld_s1, vld_s2, vld_s3;
	logic rdy0, rdy1, rdy2, rdy3;
	logic take;

	assign rdy3 = !vld_s3 || results.ready;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign rdy0 = !vld_s0 || rdy1;
	assign take = pixels.valid && rdy0;
	assign pixels.ready = rdy0;

	// line position
	logic [LINE_W-1:0] fill_q;
	logic              has_res;
	logic [POS_W-1:0]  pos_next;

	assign has_res  = fill_q >= LINE_W'({r_eff, 1'b0});
	assign pos_next = POS_W'(fill_q - LINE_W'(r_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (take) begin
				if (pixels.line_end) begin
					fill_q <= '0;
				end else if (fill_q != LINE_W'(MAX_LINE - 1)) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (rdy0) vld_s0 <= take && has_res;
			if (rdy1) vld_s1 <= vld_s0;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	// window chain and per-tap products
	logic [PIXEL_BITS-1:0] chain [NTAP+1];
	logic [PROD_W-1:0]     prod [NGRP*GRP];
	cell_ctrl_t            cell_ctrl;

	assign chain[0]         = pixels.pixel[PIXEL_BITS-1:0];
	assign cell_ctrl.shift  = take;
	assign cell_ctrl.load   = rdy1 && vld_s0;
	assign cell_ctrl.radius = r_eff;

	for (genvar k = 0; k < NGRP * GRP; k++) begin : g_tap
		if (k < NTAP) begin : g_cell
			sgls_cell #(
				.TAP        (k),
				.PIXEL_BITS (PIXEL_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (cell_ctrl),
				.wts     (wts_q),
				.pix_in  (chain[k]),
				.pix_out (chain[k+1]),
				.prod    (prod[k])
			);
		end else begin : g_pad
			assign prod[k] = '0;
		end
	end

	// position travels alongside the data
	logic [POS_W-1:0] pos_s0, pos_s1, pos_s2, pos_s3;

	// group sums
	logic [GRP_W-1:0] grp_sum [NGRP];
	logic [GRP_W-1:0] grp_s2 [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_sum[g] = '0;
			for (int i = 0; i < GRP; i++) begin
				grp_sum[g] = grp_sum[g] + GRP_W'(prod[g*GRP+i]);
			end
		end
	end

	// final sum and clip
	logic [SUM_W-1:0] total;
	logic [EXT_W-1:0] sum_ext;
	logic             sat;

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + SUM_W'(grp_s2[g]);
		end
		sum_ext = EXT_W'(total);
		sat     = sum_ext > EXT_W'(SUM_MAX);
	end

	logic [OUT_W-1:0] smoothed_s3;
	logic             sat_s3;

	always_ff @(posedge clk) begin
		if (take) begin
			pos_s0 <= pos_next;
		end
		if (rdy1 && vld_s0) begin
			pos_s1 <= pos_s0;
		end
		if (rdy2 && vld_s1) begin
			pos_s2 <= pos_s1;
			grp_s2 <= grp_sum;
		end
		if (rdy3 && vld_s2) begin
			pos_s3      <= pos_s2;
			sat_s3      <= sat;
			smoothed_s3 <= sat ? SUM_MAX : sum_ext[OUT_W-1:0];
		end
	end

	assign results.valid     = vld_s3;
	assign results.smoothed  = smoothed_s3;
	assign results.position  = pos_s3;
	assign results.saturated = sat_s3;

`include "symmetric_gauss_line_smoother_top_assert.svh"

	`SGLS_ASSERT_NEXT(a_line_restart, take && pixels.line_end, fill_q == '0, "line position not cleared after line end")
	`SGLS_ASSERT_NEXT(a_result_held, vld_s3 && !results.ready, vld_s3, "pending result dropped")
	`SGLS_ASSERT_NOW(a_clip_value, vld_s3 && sat_s3, smoothed_s3 == SUM_MAX, "clipped result not at maximum")

endmodule

`default_nettype wire

/* rtl/sgls_cell.sv */
`default_nettype none

module sgls_cell #(
	parameter int TAP        = 0,
	parameter int PIXEL_BITS = sgls_pkg::PIXEL_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sgls_pkg::cell_ctrl_t                 ctrl,
	input  sgls_pkg::weights_t                   wts,
	input  logic [PIXEL_BITS-1:0]                pix_in,
	output logic [PIXEL_BITS-1:0]                pix_out,
	output logic [PIXEL_BITS+sgls_pkg::WGT_W-1:0] prod
);
	import sgls_pkg::*;

	localparam int PROD_W = PIXEL_BITS + WGT_W;
	localparam logic [RAD_W:0] TAP_K = TAP[RAD_W:0];

	logic [PIXEL_BITS-1:0] pix_q;
	weight_t               coef_q;
	logic [PROD_W-1:0]     prod_s1;
	logic [RAD_W:0]        rad_x;
	logic [RAD_W:0]        two_r;
	logic [RAD_W:0]        tap_dist;
	weight_t               coef;

	// tap weight follows from its distance to the centre tap
	always_comb begin
		rad_x    = {1'b0, ctrl.radius};
		two_r    = {ctrl.radius, 1'b0};
		tap_dist = (TAP_K >= rad_x) ? TAP_K - rad_x : rad_x - TAP_K;
		coef     = '0;
		if (TAP_K <= two_r) begin
			for (int j = 0; j < NUM_WTS; j++) begin
				if (tap_dist == (RAD_W+1)'(j)) begin
					coef = wts[j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q  <= '0;
			coef_q <= '0;
		end else begin
			coef_q <= coef;
			if (ctrl.shift) begin
				pix_q <= pix_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			prod_s1 <= {{WGT_W{1'b0}}, pix_q} * {{PIXEL_BITS{1'b0}}, coef_q};
		end
	end

	assign pix_out = pix_q;
	assign prod    = prod_s1;

endmodule

`default_nettype wire
